@@ hdl/f2d_pkg.sv @@
`timescale 1ns / 1ps

package f2d_pkg;

  // field widths
  localparam int FLOAT_W  = 32;
  localparam int MANT_BITS = 23;
  localparam int SIG_W    = MANT_BITS + 1;
  localparam int INT_W    = 24;
  localparam int POS_W    = 5;
  localparam int DIGIT_W  = 4;
  localparam int EXP_W    = 8;

  // encoding constants
  localparam logic [EXP_W-1:0] EXP_MASK = 8'hff;
  localparam int EXP_BIAS = 127;
  localparam int RADIX    = 10;

  // default number of fractional digits
  localparam int FRACTION_DIGITS_DEF = 29;

  // one halving step travelling down the digit row
  typedef struct packed {
    logic valid;
    logic carry;
    logic first;
    logic last;
  } tok_t;

  // per-request values that repeat on every result
  typedef struct packed {
    logic             negative;
    logic [INT_W-1:0] integral;
    logic             range_error;
  } meta_t;

endpackage

@@ hdl/float32_to_exact_decimal.sv @@
`timescale 1ns / 1ps

// float32_to_exact_decimal
// Splits a binary32 pattern into sign, binary integer part and the exact
// decimal expansion of the fraction, FRACTION_DIGITS digits long.
// Input channel: in_valid / in_stall carry one in_float_bits request.
// Result channel: out_valid / out_stall carry FRACTION_DIGITS digits per
// request, first digit after the point first; out_last_digit marks the
// final digit. Sign, integer part and range error repeat on every digit of
// a request. The feed pushes one fraction bit per cycle into the row of
// digit cells while the receiver does not stall, and takes the next
// request as it pushes the last bit of the previous one.
// A new request is taken while the previous one still drains its digits.
// When the receiver stalls, the whole digit row and the feed freeze and the
// pending result holds; in_stall rises once the feed is full.
// Reset clears all control state; no request or result is pending after it.
module float32_to_exact_decimal #(
  parameter int FRACTION_DIGITS = f2d_pkg::FRACTION_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [f2d_pkg::FLOAT_W-1:0] in_float_bits,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_negative,
  output logic [f2d_pkg::INT_W-1:0]   out_integral_part,
  output logic [f2d_pkg::POS_W-1:0]   out_digit_position,
  output logic [f2d_pkg::DIGIT_W-1:0] out_digit,
  output logic                        out_range_error,
  output logic                        out_last_digit
);

  localparam int FD = FRACTION_DIGITS;

  logic                        adv;
  f2d_pkg::tok_t               tok [FD+1];
  logic [FD-1:0]               fin_v;
  logic [f2d_pkg::DIGIT_W-1:0] fin_digit [FD];
  f2d_pkg::meta_t              feed_meta;
  f2d_pkg::meta_t              em_r;
  f2d_pkg::meta_t              sel_meta;

  logic                        emit;
  logic [f2d_pkg::POS_W-1:0]   emit_pos;
  logic [f2d_pkg::DIGIT_W-1:0] emit_digit;
  logic                        emit_last;

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        out_negative_r;
  logic [f2d_pkg::INT_W-1:0]   out_integral_r;
  logic [f2d_pkg::POS_W-1:0]   out_pos_r;
  logic [f2d_pkg::DIGIT_W-1:0] out_digit_r;
  logic                        out_err_r;
  logic                        out_last_r;

  // the row moves whenever the result register can take a new digit
  assign adv = !out_valid_r || !out_stall;

  f2d_feed #(
    .FRACTION_DIGITS(FD)
  ) u_feed (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (in_valid),
    .in_float_bits(in_float_bits),
    .in_stall     (in_stall),
    .tok          (tok[0]),
    .meta         (feed_meta)
  );

  // row of digit cells
  for (genvar j = 0; j < FD; j++) begin : g_cell
    f2d_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .tok_in   (tok[j]),
      .tok_out  (tok[j+1]),
      .fin_v    (fin_v[j]),
      .fin_digit(fin_digit[j])
    );
  end

  // pick the finished digit; at most one cell finishes per advance
  always_comb begin
    emit       = |fin_v;
    emit_pos   = '0;
    emit_digit = '0;
    for (int j = 0; j < FD; j++) begin
      if (fin_v[j]) begin
        emit_pos   = emit_pos | f2d_pkg::POS_W'(j);
        emit_digit = emit_digit | fin_digit[j];
      end
    end
    emit_last = fin_v[FD-1];
    sel_meta  = fin_v[0] ? feed_meta : em_r;
  end

  // values of the request whose digits are draining
  always_ff @(posedge clk) begin
    if (adv && fin_v[0]) begin
      em_r <= feed_meta;
    end
  end

  // result register
  assign out_valid_nxt = adv ? emit : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_negative_r <= sel_meta.negative;
      out_integral_r <= sel_meta.integral;
      out_err_r      <= sel_meta.range_error;
      out_pos_r      <= emit_pos;
      out_digit_r    <= emit_digit;
      out_last_r     <= emit_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_negative       = out_negative_r;
  assign out_integral_part  = out_integral_r;
  assign out_digit_position = out_pos_r;
  assign out_digit          = out_digit_r;
  assign out_range_error    = out_err_r;
  assign out_last_digit     = out_last_r;

endmodule

@@ hdl/f2d_cell.sv @@
`timescale 1ns / 1ps

module f2d_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  f2d_pkg::tok_t               tok_in,
  output f2d_pkg::tok_t               tok_out,
  output logic                        fin_v,
  output logic [f2d_pkg::DIGIT_W-1:0] fin_digit
);

  logic [f2d_pkg::DIGIT_W-1:0] d_r;
  logic [f2d_pkg::DIGIT_W-1:0] d_nxt;
  logic [f2d_pkg::DIGIT_W-1:0] old_d;
  logic [f2d_pkg::DIGIT_W:0]   cur;
  f2d_pkg::tok_t               tok_r;
  f2d_pkg::tok_t               tok_nxt;

  // one decimal halving step: (carry*10 + digit) / 2
  always_comb begin
    old_d = tok_in.first ? '0 : d_r;
    cur   = (tok_in.carry ? (f2d_pkg::DIGIT_W+1)'(f2d_pkg::RADIX) : '0)
            + {1'b0, old_d};
    d_nxt = cur[f2d_pkg::DIGIT_W:1];
    tok_nxt       = tok_in;
    tok_nxt.carry = cur[0];
  end

  // digit storage, updated only when a step passes through
  always_ff @(posedge clk) begin
    if (adv && tok_in.valid) begin
      d_r <= d_nxt;
    end
  end

  // hand the step to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out   = tok_r;
  assign fin_v     = tok_in.valid && tok_in.last;
  assign fin_digit = d_nxt;

endmodule

@@ hdl/f2d_feed.sv @@
`timescale 1ns / 1ps

module f2d_feed #(
  parameter int FRACTION_DIGITS = f2d_pkg::FRACTION_DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [f2d_pkg::FLOAT_W-1:0] in_float_bits,
  output logic                        in_stall,
  output f2d_pkg::tok_t               tok,
  output f2d_pkg::meta_t              meta
);

  localparam int FD = FRACTION_DIGITS;
  localparam int CW = $clog2(FD);
  localparam int SW = $clog2(FD + 1);
  localparam int WW = FD + f2d_pkg::SIG_W;
  localparam logic signed [9:0] LOW_E  = 10'(f2d_pkg::MANT_BITS - FD);
  localparam logic signed [9:0] HIGH_E = 10'(f2d_pkg::MANT_BITS);
  localparam logic signed [9:0] S_OFS  = 10'(FD - f2d_pkg::MANT_BITS);
  localparam logic [CW-1:0]     LAST_CNT = CW'(FD - 1);

  logic                          active_r;
  logic                          active_nxt;
  logic [CW-1:0]                 cnt_r;
  logic [CW-1:0]                 cnt_nxt;
  logic [FD-1:0]                 w_r;
  logic [FD-1:0]                 w_nxt;
  f2d_pkg::meta_t                meta_r;
  f2d_pkg::meta_t                meta_nxt;

  logic                          take;
  logic                          accept;
  logic [f2d_pkg::EXP_W-1:0]     efield;
  logic [f2d_pkg::MANT_BITS-1:0] mant;
  logic signed [9:0]             e_s;
  logic signed [9:0]             s_full;
  logic [SW-1:0]                 shamt;
  logic                          is_zero;
  logic                          num_ok;
  logic [WW-1:0]                 wide;

  // decode the pattern and scale the significand to 2^FD
  always_comb begin
    efield  = in_float_bits[f2d_pkg::FLOAT_W-2:f2d_pkg::MANT_BITS];
    mant    = in_float_bits[f2d_pkg::MANT_BITS-1:0];
    e_s     = $signed({2'b00, efield}) - 10'sd127;
    s_full  = e_s + S_OFS;
    shamt   = s_full[SW-1:0];
    is_zero = (efield == '0) && (mant == '0);
    num_ok  = (efield != '0) && (efield != f2d_pkg::EXP_MASK)
              && (e_s >= LOW_E) && (e_s <= HIGH_E);
    wide    = num_ok ? ({{FD{1'b0}}, 1'b1, mant} << shamt) : '0;
  end

  assign take     = !active_r || (adv && (cnt_r == LAST_CNT));
  assign accept   = in_valid && take;
  assign in_stall = !take;

  // step sequencing, one fraction bit per advance, lsb first
  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    w_nxt      = w_r;
    meta_nxt   = meta_r;
    if (accept) begin
      active_nxt           = 1'b1;
      cnt_nxt              = '0;
      w_nxt                = wide[FD-1:0];
      meta_nxt.negative    = in_float_bits[f2d_pkg::FLOAT_W-1];
      meta_nxt.integral    = wide[WW-1:FD];
      meta_nxt.range_error = !num_ok && !is_zero;
    end else if (adv && active_r) begin
      w_nxt   = w_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_CNT) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    meta_r <= meta_nxt;
  end

  always_comb begin
    tok.valid = active_r;
    tok.carry = w_r[0];
    tok.first = (cnt_r == '0);
    tok.last  = (cnt_r == LAST_CNT);
  end

  assign meta = meta_r;

endmodule

@@ hdl/f2d_checker.sv @@
`timescale 1ns / 1ps

module f2d_checker #(
  parameter int FRACTION_DIGITS = f2d_pkg::FRACTION_DIGITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [f2d_pkg::FLOAT_W-1:0] in_float_bits,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_negative,
  input logic [f2d_pkg::INT_W-1:0]   out_integral_part,
  input logic [f2d_pkg::POS_W-1:0]   out_digit_position,
  input logic [f2d_pkg::DIGIT_W-1:0] out_digit,
  input logic                        out_range_error,
  input logic                        out_last_digit
);

  localparam logic [f2d_pkg::POS_W-1:0] LAST_POS = f2d_pkg::POS_W'(FRACTION_DIGITS - 1);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digit)
      && $stable(out_digit_position) && $stable(out_integral_part))
    else $error("stalled result changed");

  // nothing pending right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a rejected pattern gives no value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> out_integral_part == '0 && out_digit == '0)
    else $error("range error with nonzero value");

  // the final mark sits on the final digit position
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_digit |-> out_digit_position == LAST_POS)
    else $error("last digit at wrong position");

  // a digit is decimal
  a_digit_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit <= 4'd9)
    else $error("digit out of range");

endmodule

bind float32_to_exact_decimal f2d_checker #(
  .FRACTION_DIGITS(FRACTION_DIGITS)
) u_f2d_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int FLOAT_W   = f2d_pkg::FLOAT_W;
  localparam int MANT_BITS = f2d_pkg::MANT_BITS;
  localparam int SIG_W     = f2d_pkg::SIG_W;
  localparam int INT_W     = f2d_pkg::INT_W;
  localparam int POS_W     = f2d_pkg::POS_W;
  localparam int DIGIT_W   = f2d_pkg::DIGIT_W;
  localparam int EXP_W     = f2d_pkg::EXP_W;
  localparam int EXP_BIAS  = f2d_pkg::EXP_BIAS;
  localparam int RADIX     = f2d_pkg::RADIX;
  localparam logic [f2d_pkg::EXP_W-1:0] EXP_MASK = f2d_pkg::EXP_MASK;

  localparam int NDIG    = f2d_pkg::FRACTION_DIGITS_DEF;
  localparam int LOW_EXP = MANT_BITS - NDIG;
  localparam int HOLDOFF = 2 * NDIG + 10;

  // idling modes of the two channels
  typedef enum int {CALM, SEND_IDLE, RECV_STALL, BOTH_IDLE} pace_t;

  typedef struct {
    logic [FLOAT_W-1:0] bits;
    pace_t              pace;
  } float_req_t;

  typedef struct {
    logic               negative;
    logic [INT_W-1:0]   integral;
    logic [POS_W-1:0]   pos;
    logic [DIGIT_W-1:0] digit;
    logic               range_error;
    logic               last;
  } digit_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FLOAT_W-1:0] in_float_bits = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_negative;
  logic [INT_W-1:0]   out_integral_part;
  logic [POS_W-1:0]   out_digit_position;
  logic [DIGIT_W-1:0] out_digit;
  logic               out_range_error;
  logic               out_last_digit;

  float_req_t float_backlog[$];
  digit_res_t digits_due[$];
  pace_t      cur_pace = CALM;
  int         mismatches = 0;

  float32_to_exact_decimal uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_float_bits     (in_float_bits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_negative      (out_negative),
    .out_integral_part (out_integral_part),
    .out_digit_position(out_digit_position),
    .out_digit         (out_digit),
    .out_range_error   (out_range_error),
    .out_last_digit    (out_last_digit)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // exact decimal digits of the fraction, by repeated multiply by ten
  function automatic void expand_float(input logic [FLOAT_W-1:0] bits);
    logic [EXP_W-1:0]     efield;
    logic [MANT_BITS-1:0] mant;
    logic [SIG_W-1:0]     sig;
    logic [INT_W-1:0]     integral;
    logic                 err;
    logic [63:0]          rem;
    logic [63:0]          mask;
    int                   e;
    int                   n;
    digit_res_t           r;
    efield   = bits[30:23];
    mant     = bits[22:0];
    integral = '0;
    err      = 1'b0;
    rem      = '0;
    n        = 0;
    if (efield == '0 && mant == '0) begin
      err = 1'b0;
    end else if (efield == '0 || efield == EXP_MASK) begin
      err = 1'b1;
    end else begin
      e = int'(efield) - EXP_BIAS;
      if (e < LOW_EXP || e > MANT_BITS) begin
        err = 1'b1;
      end else begin
        sig = {1'b1, mant};
        n   = MANT_BITS - e;
        if (e >= 0) begin
          integral = sig >> n;
          rem      = 64'(sig) & ((64'd1 << n) - 64'd1);
        end else begin
          rem = 64'(sig);
        end
      end
    end
    mask = (64'd1 << n) - 64'd1;
    for (int k = 0; k < NDIG; k++) begin
      rem           = rem * RADIX;
      r.negative    = bits[31];
      r.integral    = integral;
      r.pos         = POS_W'(k);
      r.digit       = DIGIT_W'(rem >> n);
      r.range_error = err;
      r.last        = (k == NDIG - 1);
      rem           = rem & mask;
      digits_due.push_back(r);
    end
  endfunction

  function automatic int send_idle_pct(input pace_t p);
    return (p == SEND_IDLE) ? 88 : (p == BOTH_IDLE) ? 14 : 0;
  endfunction

  function automatic int recv_stall_pct(input pace_t p);
    return (p == RECV_STALL) ? 88 : (p == BOTH_IDLE) ? 14 : 0;
  endfunction

  // random pattern, mostly inside the accepted exponent span
  function automatic logic [FLOAT_W-1:0] random_float();
    int               sel;
    logic [EXP_W-1:0] ef;
    logic [22:0]      m;
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: m = '0;
      1: m = '1;
      default: m = 23'($urandom);
    endcase
    if (sel < 70) begin
      ef = EXP_W'($urandom_range(EXP_BIAS + LOW_EXP, EXP_BIAS + MANT_BITS));
    end else if (sel < 80) begin
      return $urandom;
    end else if (sel < 88) begin
      case ($urandom_range(0, 2))
        0: ef = EXP_W'(EXP_BIAS + LOW_EXP - 1);
        1: ef = EXP_W'(EXP_BIAS + MANT_BITS + 1);
        default: ef = EXP_W'($urandom_range(1, 254));
      endcase
    end else if (sel < 94) begin
      ef = '0;
    end else begin
      ef = EXP_MASK;
    end
    return {1'($urandom), ef, m};
  endfunction

  // request driver
  always @(posedge clk) begin
    logic take;
    take = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (take) begin
        expand_float(in_float_bits);
        cur_pace <= float_backlog[0].pace;
        void'(float_backlog.pop_front());
      end
      if (in_valid && !take) begin
        // stalled: hold request
      end else if (float_backlog.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct(float_backlog[0].pace)) begin
        in_valid      <= 1'b1;
        in_float_bits <= float_backlog[0].bits;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    digit_res_t want;
    logic       bad;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct(cur_pace));
      if (out_valid && !out_stall) begin
        if (digits_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected digit: pos %0d digit %0d", out_digit_position, out_digit);
        end else begin
          want = digits_due.pop_front();
          bad  = 1'b0;
          if (out_negative !== want.negative) bad = 1'b1;
          if (out_integral_part !== want.integral) bad = 1'b1;
          if (out_digit_position !== want.pos) bad = 1'b1;
          if (out_digit !== want.digit) bad = 1'b1;
          if (out_range_error !== want.range_error) bad = 1'b1;
          if (out_last_digit !== want.last) bad = 1'b1;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp neg %0b int %0d pos %0d dig %0d err %0b last %0b,",
                        " got neg %0b int %0d pos %0d dig %0d err %0b last %0b"},
                       want.negative, want.integral, want.pos, want.digit,
                       want.range_error, want.last, out_negative, out_integral_part,
                       out_digit_position, out_digit, out_range_error, out_last_digit);
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    float_req_t req;
    logic [FLOAT_W-1:0] directed[$] = '{
      32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBFC0_0000,
      32'h3F00_0000, 32'h3F7F_FFFF, 32'h3F80_0001, 32'h3C80_0000,
      32'h3CFF_FFFF, 32'hBC7F_FFFF, 32'h4B00_0000, 32'h4B7F_FFFF,
      32'h4B80_0000, 32'h0000_0001, 32'h807F_FFFF, 32'h7F80_0000,
      32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h4049_0FDB,
      32'h3DCC_CCCD, 32'h4AFF_FFFF, 32'h0080_0000, 32'h7F7F_FFFF
    };
    foreach (directed[i]) begin
      req.bits = directed[i];
      req.pace = CALM;
      float_backlog.push_back(req);
    end
    for (int i = 0; i < 256; i++) begin
      req.bits = random_float();
      req.pace = pace_t'((i / 64) % 4);
      float_backlog.push_back(req);
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (float_backlog.size() != 0 || digits_due.size() != 0) @(posedge clk);
    repeat (HOLDOFF) @(posedge clk);
    if (mismatches == 0 && digits_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
